// ===== hw/rtl/ps2mc_pkg.sv =====
// Package for the PS/2 mouse packet cursor unit.
// Holds the register index codes, reset values and packet bit positions.
// No dependencies.
package ps2mc_pkg;

  typedef enum logic [1:0] {
    CFG_EXTRA_BYTE_MODE = 2'd0,
    CFG_SCREEN_WIDTH    = 2'd1,
    CFG_SCREEN_HEIGHT   = 2'd2
  } cfg_idx_t;

  typedef logic [15:0] coord_t;

  localparam int unsigned AUX_DATA_BIT = 5;
  localparam int unsigned X_SIGN_BIT   = 4;
  localparam int unsigned Y_SIGN_BIT   = 5;

  localparam coord_t EDGE_MARGIN        = 16'd17;
  localparam coord_t SCREEN_WIDTH_RST   = 16'd1024;
  localparam coord_t SCREEN_HEIGHT_RST  = 16'd768;

  localparam logic [1:0] POS_FIRST  = 2'd0;
  localparam logic [1:0] POS_X      = 2'd1;
  localparam logic [1:0] POS_Y      = 2'd2;
  localparam logic [1:0] POS_EXTRA  = 2'd3;

endpackage

// ===== hw/rtl/ps2_mouse_packet_cursor_unit.sv =====
// PS/2 mouse packet cursor unit: packet assembly, cursor move and clamp.
// Each beat is held in the input register, and a completed packet's result then in the
// result register, which drives the outputs.
// Throughput: one input beat per cycle while in_stall is low; packet state updates as each
// auxiliary beat leaves the input register, so the next beat sees it.
// Reset (rst_n low, synchronous): packet position, held bytes and cursor go to zero,
// extra_byte_mode to 0, screen size to 1024 x 768.
// Depends on ps2mc_pkg.
module ps2_mouse_packet_cursor_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_controller_status,
  input  logic [7:0]  in_data_byte,
  input  logic [31:0] in_tick_time,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_button_flags,
  output logic [7:0]  out_x_motion,
  output logic [7:0]  out_y_motion,
  output logic [7:0]  out_extra_flags,
  output logic [31:0] out_event_time,
  output logic [15:0] out_pointer_x,
  output logic [15:0] out_pointer_y,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic                 extra_mode_r;
  ps2mc_pkg::coord_t    width_r;
  ps2mc_pkg::coord_t    height_r;

  logic                 s1_v_r;
  logic [7:0]           s1_status_r;
  logic [7:0]           s1_data_r;
  logic [31:0]          s1_tick_r;

  logic [1:0]           pos_r, pos_nxt;
  logic [7:0]           btn_r, btn_nxt;
  logic [7:0]           xm_r, xm_nxt;
  logic [7:0]           ym_r, ym_nxt;
  logic [7:0]           ext_r, ext_nxt;
  ps2mc_pkg::coord_t    col_r, col_nxt;
  ps2mc_pkg::coord_t    row_r, row_nxt;

  logic                 out_valid_r;
  logic [7:0]           out_btn_r, out_xm_r, out_ym_r, out_ext_r;
  logic [31:0]          out_time_r;
  ps2mc_pkg::coord_t    out_x_r, out_y_r;

  logic                 out_free;
  logic                 s1_fire;
  logic                 in_fire;
  logic                 s1_aux;
  logic                 s1_last;
  ps2mc_pkg::coord_t    dx, dy, col_mv, row_mv, lim_x, lim_y;

  assign cfg_ready = 1'b1;

  assign out_free = !out_valid_r || !out_stall;
  assign s1_fire  = s1_v_r && out_free;
  assign in_stall = s1_v_r && !out_free;
  assign in_fire  = in_valid && !in_stall;

  assign s1_aux  = s1_status_r[ps2mc_pkg::AUX_DATA_BIT];
  assign s1_last = s1_aux && ((pos_r == ps2mc_pkg::POS_EXTRA) ||
                   ((pos_r == ps2mc_pkg::POS_Y) && !extra_mode_r));

  assign lim_x = (width_r < ps2mc_pkg::EDGE_MARGIN) ? '0 : width_r - ps2mc_pkg::EDGE_MARGIN;
  assign lim_y = (height_r < ps2mc_pkg::EDGE_MARGIN) ? '0 : height_r - ps2mc_pkg::EDGE_MARGIN;

  always_comb begin
    pos_nxt = pos_r;
    btn_nxt = btn_r;
    xm_nxt  = xm_r;
    ym_nxt  = ym_r;
    ext_nxt = ext_r;
    case (pos_r)
      ps2mc_pkg::POS_FIRST: begin
        btn_nxt = s1_data_r;
        pos_nxt = ps2mc_pkg::POS_X;
      end
      ps2mc_pkg::POS_X: begin
        xm_nxt  = s1_data_r;
        pos_nxt = ps2mc_pkg::POS_Y;
      end
      ps2mc_pkg::POS_Y: begin
        ym_nxt  = s1_data_r;
        pos_nxt = extra_mode_r ? ps2mc_pkg::POS_EXTRA : ps2mc_pkg::POS_FIRST;
      end
      default: begin
        ext_nxt = s1_data_r;
        pos_nxt = ps2mc_pkg::POS_FIRST;
      end
    endcase

    dx     = {{8{btn_nxt[ps2mc_pkg::X_SIGN_BIT]}}, xm_nxt};
    dy     = {{8{btn_nxt[ps2mc_pkg::Y_SIGN_BIT]}}, ym_nxt};
    col_mv = col_r + dx;
    row_mv = row_r - dy;
    col_nxt = col_mv;
    row_nxt = row_mv;
    if (col_mv > lim_x) begin
      col_nxt = dx[15] ? '0 : lim_x;
    end
    if (row_mv > lim_y) begin
      row_nxt = dy[15] ? lim_y : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      extra_mode_r <= 1'b0;
      width_r      <= ps2mc_pkg::SCREEN_WIDTH_RST;
      height_r     <= ps2mc_pkg::SCREEN_HEIGHT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ps2mc_pkg::CFG_EXTRA_BYTE_MODE: extra_mode_r <= cfg_data[0];
        ps2mc_pkg::CFG_SCREEN_WIDTH:    width_r      <= cfg_data;
        ps2mc_pkg::CFG_SCREEN_HEIGHT:   height_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_fire) begin
      s1_v_r <= 1'b1;
    end else if (s1_fire) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_status_r <= in_controller_status;
      s1_data_r   <= in_data_byte;
      s1_tick_r   <= in_tick_time;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= ps2mc_pkg::POS_FIRST;
      btn_r <= '0;
      xm_r  <= '0;
      ym_r  <= '0;
      ext_r <= '0;
      col_r <= '0;
      row_r <= '0;
    end else if (s1_fire && s1_aux) begin
      pos_r <= pos_nxt;
      btn_r <= btn_nxt;
      xm_r  <= xm_nxt;
      ym_r  <= ym_nxt;
      ext_r <= ext_nxt;
      if (s1_last) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_fire && s1_last;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_last) begin
      out_btn_r  <= btn_nxt;
      out_xm_r   <= xm_nxt;
      out_ym_r   <= ym_nxt;
      out_ext_r  <= ext_nxt;
      out_time_r <= s1_tick_r;
      out_x_r    <= col_nxt;
      out_y_r    <= row_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_button_flags = out_btn_r;
  assign out_x_motion     = out_xm_r;
  assign out_y_motion     = out_ym_r;
  assign out_extra_flags  = out_ext_r;
  assign out_event_time   = out_time_r;
  assign out_pointer_x    = out_x_r;
  assign out_pointer_y    = out_y_r;

  a_stall_needs_beat: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_v_r |-> !in_stall)
    else $error("input stalled with empty input register");

  a_result_from_aux: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_v_r && s1_aux))
    else $error("result raised without an auxiliary beat");

  a_packet_restart: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && s1_last |=> pos_r == ps2mc_pkg::POS_FIRST)
    else $error("packet position not cleared after last byte");

endmodule

// ===== tb/sv/ps2_mouse_packet_cursor_unit_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for ps2_mouse_packet_cursor_unit: packet assembly and cursor clamp.
// A cursor_tracker class predicts each packet; depends on ps2mc_pkg and the unit's RTL.

module ps2_mouse_packet_cursor_unit_test;

  localparam int PIPE_LATENCY = 2;
  localparam int SETTLE_CYCLES = PIPE_LATENCY + 4;
  localparam int QUIET_LIMIT = 4000;
  localparam int PHASE_COUNT = 8;
  localparam int PHASE_BYTES = 100;

  typedef struct packed {
    logic [7:0]  buttons;
    logic [7:0]  x_raw;
    logic [7:0]  y_raw;
    logic [7:0]  extra;
    logic [31:0] stamp;
    logic [15:0] ptr_x;
    logic [15:0] ptr_y;
  } packet_t;

  class cursor_tracker;
    bit                 four_byte = 1'b0;
    ps2mc_pkg::coord_t  width = ps2mc_pkg::SCREEN_WIDTH_RST;
    ps2mc_pkg::coord_t  height = ps2mc_pkg::SCREEN_HEIGHT_RST;
    logic [1:0]         pos = ps2mc_pkg::POS_FIRST;
    logic [7:0]         buttons = '0;
    logic [7:0]         x_raw = '0;
    logic [7:0]         y_raw = '0;
    logic [7:0]         extra = '0;
    ps2mc_pkg::coord_t  col = '0;
    ps2mc_pkg::coord_t  row = '0;
    packet_t            expected_packets[$];
    int                 error_count = 0;
    int                 reads = 0;
    int                 mouse_bytes = 0;
    int                 packets_checked = 0;
    int                 reg_writes = 0;

    function void write_reg(ps2mc_pkg::cfg_idx_t idx, logic [15:0] val);
      reg_writes++;
      case (idx)
        ps2mc_pkg::CFG_EXTRA_BYTE_MODE: four_byte = val[0];
        ps2mc_pkg::CFG_SCREEN_WIDTH:    width = val;
        ps2mc_pkg::CFG_SCREEN_HEIGHT:   height = val;
        default: ;
      endcase
    endfunction

    function ps2mc_pkg::coord_t edge_limit(ps2mc_pkg::coord_t size);
      return (size < ps2mc_pkg::EDGE_MARGIN) ? ps2mc_pkg::coord_t'(0) :
             ps2mc_pkg::coord_t'(size - ps2mc_pkg::EDGE_MARGIN);
    endfunction

    function void note_read(logic [7:0] st, logic [7:0] db, logic [31:0] tk);
      ps2mc_pkg::coord_t  dx;
      ps2mc_pkg::coord_t  dy;
      ps2mc_pkg::coord_t  lim_x;
      ps2mc_pkg::coord_t  lim_y;
      packet_t            pkt;
      reads++;
      if (!st[ps2mc_pkg::AUX_DATA_BIT]) return;
      mouse_bytes++;
      case (pos)
        ps2mc_pkg::POS_FIRST: begin
          buttons = db;
          pos = ps2mc_pkg::POS_X;
          return;
        end
        ps2mc_pkg::POS_X: begin
          x_raw = db;
          pos = ps2mc_pkg::POS_Y;
          return;
        end
        ps2mc_pkg::POS_Y: begin
          y_raw = db;
          if (four_byte) begin
            pos = ps2mc_pkg::POS_EXTRA;
            return;
          end
        end
        default: extra = db;
      endcase
      pos = ps2mc_pkg::POS_FIRST;
      dx = {{8{buttons[ps2mc_pkg::X_SIGN_BIT]}}, x_raw};
      dy = {{8{buttons[ps2mc_pkg::Y_SIGN_BIT]}}, y_raw};
      col = col + dx;
      row = row - dy;
      lim_x = edge_limit(width);
      lim_y = edge_limit(height);
      if (col > lim_x) col = dx[15] ? ps2mc_pkg::coord_t'(0) : lim_x;
      if (row > lim_y) row = dy[15] ? lim_y : ps2mc_pkg::coord_t'(0);
      pkt.buttons = buttons;
      pkt.x_raw = x_raw;
      pkt.y_raw = y_raw;
      pkt.extra = extra;
      pkt.stamp = tk;
      pkt.ptr_x = col;
      pkt.ptr_y = row;
      expected_packets.push_back(pkt);
    endfunction

    function void compare_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
      if (exp_val !== act_val) begin
        error_count++;
        $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
      end
    endfunction

    function void check_packet(packet_t got);
      packet_t exp_pkt;
      if (expected_packets.size() == 0) begin
        error_count++;
        $error("unexpected packet: buttons 0x%0h x 0x%0h y 0x%0h", got.buttons, got.x_raw,
               got.y_raw);
        return;
      end
      exp_pkt = expected_packets.pop_front();
      packets_checked++;
      compare_field("button_flags", 32'(exp_pkt.buttons), 32'(got.buttons));
      compare_field("x_motion", 32'(exp_pkt.x_raw), 32'(got.x_raw));
      compare_field("y_motion", 32'(exp_pkt.y_raw), 32'(got.y_raw));
      compare_field("extra_flags", 32'(exp_pkt.extra), 32'(got.extra));
      compare_field("event_time", exp_pkt.stamp, got.stamp);
      compare_field("pointer_x", 32'(exp_pkt.ptr_x), 32'(got.ptr_x));
      compare_field("pointer_y", 32'(exp_pkt.ptr_y), 32'(got.ptr_y));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_controller_status = '0;
  logic [7:0]  in_data_byte = '0;
  logic [31:0] in_tick_time = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_button_flags;
  logic [7:0]  out_x_motion;
  logic [7:0]  out_y_motion;
  logic [7:0]  out_extra_flags;
  logic [31:0] out_event_time;
  logic [15:0] out_pointer_x;
  logic [15:0] out_pointer_y;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  cursor_tracker tracker;
  int burst_left = 0;
  int quiet_cycles = 0;
  int rx_mode = 0;
  int rx_left = 0;
  int rx_phase = 0;

  ps2_mouse_packet_cursor_unit u_top (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_controller_status (in_controller_status),
    .in_data_byte         (in_data_byte),
    .in_tick_time         (in_tick_time),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_button_flags     (out_button_flags),
    .out_x_motion         (out_x_motion),
    .out_y_motion         (out_y_motion),
    .out_extra_flags      (out_extra_flags),
    .out_event_time       (out_event_time),
    .out_pointer_x        (out_pointer_x),
    .out_pointer_y        (out_pointer_y),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

  always #5 clk = ~clk;

  // Receiver stall pattern: free-running, random, mostly-stalled and periodic stretches.
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = $urandom_range(8, 64);
    end
    rx_left--;
    rx_phase++;
    case (rx_mode)
      0: out_stall = 1'b0;
      1: out_stall = 1'($urandom_range(0, 1));
      2: out_stall = ($urandom_range(0, 7) != 0);
      default: out_stall = ((rx_phase % 5) < 2);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      tracker.check_packet({out_button_flags, out_x_motion, out_y_motion, out_extra_flags,
                            out_event_time, out_pointer_x, out_pointer_y});
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("ps2_mouse_packet_cursor_unit regression: fail");
        $finish;
      end
    end
  end

  task automatic send_read(logic [7:0] st, logic [7:0] db, logic [31:0] tk);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
      repeat (gap) begin
        @(negedge clk);
        in_valid = 1'b0;
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
    end
    burst_left--;
    @(negedge clk);
    in_valid = 1'b1;
    in_controller_status = st;
    in_data_byte = db;
    in_tick_time = tk;
    do @(posedge clk); while (in_stall);
    tracker.note_read(st, db, tk);
  endtask

  // Drop valid, drain every pending packet, then let the pipeline empty.
  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    burst_left = 0;
    while (tracker.expected_packets.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(ps2mc_pkg::cfg_idx_t idx, logic [15:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    tracker.write_reg(idx, val);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [15:0] pick_size();
    case ($urandom_range(0, 5))
      0: return 16'd17;
      1: return 16'd65535;
      2: return 16'($urandom_range(17, 64));
      3: return 16'($urandom_range(17, 65535));
      default: return 16'($urandom_range(200, 2000));
    endcase
  endfunction

  initial begin
    int          sent;
    int          kind;
    int          len;
    logic [7:0]  db;
    tracker = new();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: ignored read, wrap toward zero, wrap upward, clamp to limit on tiny screens,
    // four-byte packet, and mode changes in the middle of a packet.
    send_read(8'hDF, 8'hFF, 32'hFFFF_FFFF);
    send_read(8'h20, 8'h18, 32'h0000_0000);
    send_read(8'hFF, 8'h01, 32'h0000_0000);
    send_read(8'h20, 8'h00, 32'h0000_0000);
    send_read(8'hFF, 8'h08, 32'h1234_5678);
    send_read(8'h20, 8'hFF, 32'h8000_0000);
    send_read(8'hFF, 8'hFF, 32'hFFFF_FFFF);
    send_read(8'h20, 8'h28, 32'h0000_0001);
    send_read(8'h3F, 8'h80, 32'h0000_0002);
    send_read(8'hE0, 8'h00, 32'h0000_0003);
    wait_idle();
    write_reg(ps2mc_pkg::CFG_SCREEN_WIDTH, 16'd17);
    write_reg(ps2mc_pkg::CFG_SCREEN_HEIGHT, 16'd17);
    send_read(8'h20, 8'h28, 32'hA5A5_A5A5);
    send_read(8'h20, 8'h7F, 32'h5A5A_5A5A);
    send_read(8'h20, 8'h01, 32'hDEAD_BEEF);
    wait_idle();
    write_reg(ps2mc_pkg::CFG_EXTRA_BYTE_MODE, 16'd1);
    write_reg(ps2mc_pkg::CFG_SCREEN_WIDTH, 16'd65535);
    write_reg(ps2mc_pkg::CFG_SCREEN_HEIGHT, 16'd65535);
    send_read(8'hFF, 8'hFF, 32'h0000_0010);
    send_read(8'hFF, 8'h00, 32'h0000_0011);
    send_read(8'hFF, 8'h80, 32'h0000_0012);
    send_read(8'hFF, 8'hFF, 32'h0000_0013);
    send_read(8'h20, 8'h00, 32'h0000_0020);
    send_read(8'h20, 8'h10, 32'h0000_0021);
    send_read(8'h20, 8'h20, 32'h0000_0022);
    wait_idle();
    write_reg(ps2mc_pkg::CFG_EXTRA_BYTE_MODE, 16'd0);
    send_read(8'h20, 8'h5A, 32'h0000_0023);
    send_read(8'h20, 8'h10, 32'h0000_0030);
    send_read(8'h20, 8'h01, 32'h0000_0031);
    wait_idle();
    write_reg(ps2mc_pkg::CFG_EXTRA_BYTE_MODE, 16'd1);
    send_read(8'h20, 8'h02, 32'h0000_0032);
    send_read(8'h20, 8'hA5, 32'h0000_0033);

    // Random: mostly well-formed packets with random content, plus noise and stray bytes.
    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      wait_idle();
      write_reg(ps2mc_pkg::CFG_EXTRA_BYTE_MODE, 16'($urandom_range(0, 1)));
      write_reg(ps2mc_pkg::CFG_SCREEN_WIDTH, pick_size());
      write_reg(ps2mc_pkg::CFG_SCREEN_HEIGHT, pick_size());
      sent = 0;
      while (sent < PHASE_BYTES) begin
        kind = $urandom_range(0, 99);
        if (kind < 12) begin
          send_read(8'($urandom_range(0, 255)) & 8'hDF, 8'($urandom_range(0, 255)), $urandom());
        end else if (kind < 17) begin
          send_read(8'($urandom_range(0, 255)) | 8'h20, 8'($urandom_range(0, 255)), $urandom());
          sent++;
        end else begin
          len = tracker.four_byte ? 4 : 3;
          for (int b = 0; b < len; b++) begin
            if ($urandom_range(0, 9) == 0)
              send_read(8'($urandom_range(0, 255)) & 8'hDF, 8'($urandom_range(0, 255)),
                        $urandom());
            case ($urandom_range(0, 7))
              0: db = 8'h00;
              1: db = 8'hFF;
              2: db = 8'h80;
              3: db = 8'h7F;
              default: db = 8'($urandom_range(0, 255));
            endcase
            send_read(8'($urandom_range(0, 255)) | 8'h20, db, $urandom());
          end
          sent += len;
        end
      end
    end

    wait_idle();
    if (tracker.expected_packets.size() != 0) begin
      tracker.error_count++;
      $error("%0d expected packets never arrived", tracker.expected_packets.size());
    end
    $display("Covered %0d controller reads, %0d of them mouse bytes, across %0d register writes.",
             tracker.reads, tracker.mouse_bytes, tracker.reg_writes);
    $display("Checked %0d packets; %0d mismatches.", tracker.packets_checked,
             tracker.error_count);
    if (tracker.error_count == 0)
      $display("ps2_mouse_packet_cursor_unit regression: pass");
    else
      $display("ps2_mouse_packet_cursor_unit regression: fail");
    $finish;
  end

endmodule
